@@ src/ieeehex_pkg.sv @@
// Package for the IEEE double to base-16 real converter.
// Holds status codes, the classified-beat struct and shared widths; no dependencies.
package ieeehex_pkg;

    localparam int unsigned FracBits = 56;
    localparam int unsigned ExpBias  = 64;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_INVALID   = 2'd3
    } status_t;

    // Classified beat passed from front to back.
    typedef struct packed {
        logic          sign;
        logic          special;   // result fixed by status alone
        status_t       status;
        logic [52:0]   mant;      // normalized, leading one at bit 52
        logic [1:0]    shift;     // p mod 4
        logic [6:0]    ebyte;     // exponent + 64
    } class_t;

endpackage

@@ src/ieeehex_front.sv @@
// Front end: decodes the double, normalizes subnormals, classifies range.
// Depends on ieeehex_pkg.
module ieeehex_front
(
    input  logic [63:0]          ieee_bits,
    output ieeehex_pkg::class_t  cls
);

    logic [10:0] bexp;
    logic [51:0] frac;
    logic [5:0]  lz;
    logic [52:0] norm;
    logic [12:0] p;      // p + 1076, always non-negative
    logic [10:0] q;      // floor(p/4) + 269
    logic [11:0] eb;     // ebyte + 205  (x + 64 = q - 268 + 64)

    assign bexp = ieee_bits[62:52];
    assign frac = ieee_bits[51:0];

    always_comb
    begin
        lz = 6'd0;
        for (int i = 0; i < 52; i++)
        begin
            if (frac[i])
            begin
                lz = 6'(51 - i);
            end
        end
    end

    always_comb
    begin
        if (bexp == 11'd0)
        begin
            // {frac, 0} already moves the top fraction bit to 52; lz more bits finish it
            norm = {frac, 1'b0} << lz;
            p    = 13'd54 - 13'(lz) - 13'd1 + 13'd0;   // -1023 - lz + 1076 = 53 - lz
        end
        else
        begin
            norm = {1'b1, frac};
            p    = 13'(bexp) + 13'd53;                 // bexp - 1023 + 1076
        end
        q  = p[12:2];
        eb = 12'(q) + 12'd1 - 12'd269 + 12'd64 + 12'd205;   // ebyte + 205
    end

    always_comb
    begin
        cls.sign    = ieee_bits[63];
        cls.mant    = norm;
        cls.shift   = p[1:0];
        cls.ebyte   = 7'(eb - 12'd205);
        cls.special = 1'b1;
        cls.status  = ieeehex_pkg::ST_OK;
        if (bexp == 11'h7FF)
        begin
            cls.status = ieeehex_pkg::ST_INVALID;
        end
        else if (bexp == 11'd0 && frac == 52'd0)
        begin
            cls.status = ieeehex_pkg::ST_OK;
        end
        else if (eb > 12'd332)
        begin
            cls.status = ieeehex_pkg::ST_OVERFLOW;
        end
        else if (eb < 12'd205)
        begin
            cls.status = ieeehex_pkg::ST_UNDERFLOW;
        end
        else
        begin
            cls.special = 1'b0;
        end
    end

endmodule

@@ src/ieeehex_back.sv @@
// Back end: aligns the significand and packs the base-16 real.
// Depends on ieeehex_pkg.
module ieeehex_back
(
    input  ieeehex_pkg::class_t  cls,
    output logic [63:0]          hex_real_bits,
    output logic [1:0]           status
);

    logic [55:0] frac;

    assign frac = 56'(cls.mant) << cls.shift;

    always_comb
    begin
        status = cls.status;
        if (!cls.special)
        begin
            hex_real_bits = {cls.sign, cls.ebyte, frac};
        end
        else if (cls.status == ieeehex_pkg::ST_OVERFLOW)
        begin
            hex_real_bits = {cls.sign, 7'h7F, {56{1'b1}}};
        end
        else
        begin
            hex_real_bits = 64'd0;
        end
    end

endmodule

@@ src/ieee_double_to_hex_real.sv @@
// IEEE double to base-16 excess-64 real converter, top level.
// The done strobe follows the start beat through cls_vld_reg and then done_reg; throughput one beat per cycle.
// The front stage classifies into a one-entry register, the back stage packs into the output.
// busy is never raised: the receiver cannot stall, so the queue never fills.
// Reset (rst_n, async, active low) clears the valid flags; payload is not reset.
// Depends on ieeehex_pkg, ieeehex_front, ieeehex_back.
module ieee_double_to_hex_real
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [63:0] ieee_bits,
    output logic        done,
    output logic [63:0] hex_real_bits,
    output logic [1:0]  status
);

    ieeehex_pkg::class_t cls_next;
    ieeehex_pkg::class_t cls_reg;
    logic                cls_vld_reg;
    logic [63:0]         hex_next;
    logic [1:0]          status_next;
    logic [63:0]         hex_reg;
    logic [1:0]          status_reg;
    logic                done_reg;

    ieeehex_front u_front
    (
        .ieee_bits (ieee_bits),
        .cls       (cls_next)
    );

    ieeehex_back u_back
    (
        .cls           (cls_reg),
        .hex_real_bits (hex_next),
        .status        (status_next)
    );

    // Advance valid flags each cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cls_vld_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            cls_vld_reg <= start;
            done_reg    <= cls_vld_reg;
        end
    end

    // Hold payload with each beat.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            cls_reg <= cls_next;
        end
        if (cls_vld_reg)
        begin
            hex_reg    <= hex_next;
            status_reg <= status_next;
        end
    end

    assign busy          = 1'b0;
    assign done          = done_reg;
    assign hex_real_bits = hex_reg;
    assign status        = status_reg;

endmodule

@@ test/tb_ieee_double_to_hex_real.sv @@
// Testbench for the IEEE double to base-16 real converter (ieee_double_to_hex_real).
// Drives start beats, predicts each converted word in a scoreboard class, checks done beats.
// Depends on ieeehex_pkg and the converter RTL.
`timescale 1ns / 1ps

module tb_ieee_double_to_hex_real;

    // Expected conversion results, one per accepted start beat.
    class hex_real_scoreboard;
        logic [63:0]          exp_word_q[$];
        ieeehex_pkg::status_t exp_stat_q[$];
        int                   errors;
        int                   checked;

        // Predict the base-16 real for one double bit pattern.
        function void note_input(logic [63:0] bits);
            logic                 sgn;
            logic [10:0]          bexp;
            logic [52:0]          mant;
            int                   p;
            int                   x;
            int                   ebyte;
            int                   shift;
            logic [63:0]          word;
            ieeehex_pkg::status_t st;
            sgn  = bits[63];
            bexp = bits[62:52];
            mant = {1'b0, bits[51:0]};
            word = '0;
            st   = ieeehex_pkg::ST_OK;
            if (bexp == 11'h7FF)
            begin
                st = ieeehex_pkg::ST_INVALID;
            end
            else if (bexp == 0 && mant == 0)
            begin
                st = ieeehex_pkg::ST_OK;
            end
            else
            begin
                if (bexp == 0)
                begin
                    // subnormal: normalize so the leading one lands at bit 52
                    p = -1022;
                    while (mant[52] == 1'b0)
                    begin
                        mant = mant << 1;
                        p--;
                    end
                end
                else
                begin
                    mant[52] = 1'b1;
                    p = int'(bexp) - 1023;
                end
                x = (p + 1076) / 4 - 268;
                ebyte = x + ieeehex_pkg::ExpBias;
                if (ebyte > 127)
                begin
                    word = {sgn, 7'h7F, {ieeehex_pkg::FracBits{1'b1}}};
                    st = ieeehex_pkg::ST_OVERFLOW;
                end
                else if (ebyte < 0)
                begin
                    st = ieeehex_pkg::ST_UNDERFLOW;
                end
                else
                begin
                    shift = p - 4 * (x - 1);
                    word = {sgn, 7'(ebyte), 56'({3'b0, mant} << shift)};
                end
            end
            exp_word_q.insert(exp_word_q.size(), word);
            exp_stat_q.insert(exp_stat_q.size(), st);
        endfunction

        // Compare one done beat against the oldest expectation.
        function void check_result(logic [63:0] word, logic [1:0] st);
            logic [63:0]          ew;
            ieeehex_pkg::status_t es;
            if (exp_word_q.size() == 0)
            begin
                $display("%0t: unexpected result word %h status %0d", $time, word, st);
                errors++;
                return;
            end
            ew = exp_word_q.pop_front();
            es = exp_stat_q.pop_front();
            checked++;
            if (word !== ew)
            begin
                $display("%0t: hex_real_bits expected %h actual %h", $time, ew, word);
                errors++;
            end
            if (st !== es)
            begin
                $display("%0t: status expected %0d actual %0d", $time, es, st);
                errors++;
            end
        endfunction
    endclass

    localparam int CycleLimit = 200000;
    localparam int DrainCycles = 8;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic [63:0] ieee_bits = '0;
    logic        busy;
    logic        done;
    logic [63:0] hex_real_bits;
    logic [1:0]  status;

    hex_real_scoreboard sb = new();
    int cycles = 0;
    int n_sent = 0;
    bit calm = 1'b0;   // set during the stretch with no idle gaps

    ieee_double_to_hex_real u_top
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .ieee_bits     (ieee_bits),
        .done          (done),
        .hex_real_bits (hex_real_bits),
        .status        (status)
    );

    always #5 clk = ~clk;

    // Watchdog: end the run if it hangs.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CycleLimit)
        begin
            $display("Timeout after %0d cycles", cycles);
            $display("Regression FAIL");
            $finish;
        end
    end

    // Sample done beats at the rising edge; the receiver never stalls.
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(hex_real_bits, status);
    end

    // Send one beat: hold start until accepted, then drop it unless another follows.
    task automatic send_beat(logic [63:0] bits);
        if (!calm)
        begin
            while ($urandom_range(99) < 11)
            begin
                start <= 1'b0;
                @(negedge clk);
            end
        end
        start     <= 1'b1;
        ieee_bits <= bits;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_input(bits);
        n_sent++;
        @(negedge clk);
    endtask

    // Build a random double: pick the exponent class so that every region is reached.
    function automatic logic [63:0] random_double();
        logic [63:0] b;
        int          k;
        b = {$urandom, $urandom};
        k = $urandom_range(9);
        case (k)
            0: b[62:52] = 11'h7FF;                        // infinity or NaN
            1: b[62:52] = 11'h000;                        // subnormal
            2: b[62:52] = 11'(1023 + 248 + $urandom_range(12));  // near overflow
            3: b[62:52] = 11'(1023 - 260 + $urandom_range(12));  // near underflow
            4:
            begin
                b[62:52] = 11'h000;
                b[51:0]  = 52'(1) << $urandom_range(51); // deep subnormal
            end
            default: ;
        endcase
        return b;
    endfunction

    initial
    begin
        logic [63:0] dir[$];
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed beats: zeros, infinities, NaN, subnormal edges, range edges, 1.0.
        dir = '{64'h0, 64'h8000_0000_0000_0000, 64'h7FF0_0000_0000_0000,
                64'hFFF0_0000_0000_0000, 64'h7FF8_0000_0000_0001, 64'hFFFF_FFFF_FFFF_FFFF,
                64'h0000_0000_0000_0001, 64'h800F_FFFF_FFFF_FFFF, 64'h0010_0000_0000_0000,
                64'h3FF0_0000_0000_0000, 64'hBFF0_0000_0000_0000, 64'h7FEF_FFFF_FFFF_FFFF,
                64'h4FAF_FFFF_FFFF_FFFF, 64'h4FB0_0000_0000_0000, 64'hCFB0_0000_0000_0000,
                64'h2EFF_FFFF_FFFF_FFFF, 64'h2F00_0000_0000_0000, 64'h2EF0_0000_0000_0000,
                64'h3FB0_0000_0000_0000, 64'h3FAF_FFFF_FFFF_FFFF, 64'h5555_5555_5555_5555,
                64'hAAAA_AAAA_AAAA_AAAA};
        foreach (dir[i])
            send_beat(dir[i]);

        // Random beats, with a calm stretch in the middle.
        for (int i = 0; i < 1200; i++)
        begin
            calm = (i >= 500 && i < 700);
            send_beat(random_double());
        end
        start <= 1'b0;

        // Drain: wait for outstanding results, then a few more cycles.
        while (sb.exp_word_q.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);

        $display("Sent %0d doubles, checked %0d results across zero, subnormal,", n_sent,
                 sb.checked);
        $display("normal, overflow, underflow and infinity/NaN classes");
        if (sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
